// File: src/gblf_pkg.sv
// ----------------------------------------------------------------------------
// gblf_pkg
// Shared sizes, types and helpers of the grid boundary line finder.
// ----------------------------------------------------------------------------
package gblf_pkg;

  localparam int MaxRows = 16;
  localparam int MaxCols = 16;

  localparam int RegW      = 5;
  localparam int EntryW    = 5;
  localparam int RowSizeW  = $clog2(MaxRows + 1);
  localparam int ColSizeW  = $clog2(MaxCols + 1);
  localparam int RowIdxW   = (MaxRows > 1) ? $clog2(MaxRows) : 1;
  localparam int ColIdxW   = (MaxCols > 1) ? $clog2(MaxCols) : 1;
  localparam int RowFlagW  = MaxRows + 1;
  localparam int ColFlagW  = MaxCols + 1;
  localparam int AddrW     = 3;
  localparam int DataW     = 32;

  localparam logic [AddrW-1:0] AddrGridRows = AddrW'(0);
  localparam logic [AddrW-1:0] AddrGridCols = AddrW'(4);

  localparam logic KindHeader   = 1'b0;
  localparam logic KindPosition = 1'b1;
  localparam logic AxisCol      = 1'b0;
  localparam logic AxisRow      = 1'b1;

  typedef struct packed {
    logic [ColFlagW-1:0] col_flags;
    logic [RowFlagW-1:0] row_flags;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_COL_HDR,
    BK_COL_POS,
    BK_ROW_HDR,
    BK_ROW_POS
  } back_state_t;

  function automatic logic [EntryW-1:0] lowest_set(input logic [ColFlagW+RowFlagW-1:0] v);
    logic [EntryW-1:0] idx;
    idx = '0;
    for (int i = ColFlagW + RowFlagW - 1; i >= 0; i--) begin
      if (v[i]) begin
        idx = EntryW'(i);
      end
    end
    return idx;
  endfunction

endpackage

// File: src/gblf_front.sv
// ----------------------------------------------------------------------------
// gblf_front
// Accepts cells, marks column and row boundaries, hands finished grids on.
// ----------------------------------------------------------------------------
module gblf_front (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              clear,
  input  logic [gblf_pkg::RowSizeW-1:0]     rows,
  input  logic [gblf_pkg::ColSizeW-1:0]     cols,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [31:0]                cell_value,
  input  gblf_pkg::queue_status_t           q_status,
  output logic                              push,
  output gblf_pkg::job_t                    push_job
);

  logic [gblf_pkg::MaxCols-1:0]  previous_row_mask, previous_row_mask_next;
  logic [gblf_pkg::ColFlagW-1:0] column_boundary_flags, column_boundary_flags_next;
  logic [gblf_pkg::RowFlagW-1:0] row_boundary_flags, row_boundary_flags_next;
  logic                          left_cell_nonzero, left_cell_nonzero_next;
  logic [gblf_pkg::RowIdxW-1:0]  current_row, current_row_next;
  logic [gblf_pkg::ColIdxW-1:0]  current_col, current_col_next;

  logic accept, nz, above, last_col, last_row;

  assign in_stall = q_status.full;
  assign accept   = in_valid && !q_status.full;
  assign nz       = (cell_value != 32'sd0);
  assign above    = (current_row == '0) ? 1'b0 : previous_row_mask[current_col];
  assign last_col = (gblf_pkg::ColSizeW'(current_col) + gblf_pkg::ColSizeW'(1)) == cols;
  assign last_row = (gblf_pkg::RowSizeW'(current_row) + gblf_pkg::RowSizeW'(1)) == rows;

  always_comb begin
    column_boundary_flags_next = column_boundary_flags;
    row_boundary_flags_next    = row_boundary_flags;
    previous_row_mask_next     = previous_row_mask;
    left_cell_nonzero_next     = nz;
    current_col_next           = current_col + gblf_pkg::ColIdxW'(1);
    current_row_next           = current_row;
    if (nz != left_cell_nonzero) begin
      column_boundary_flags_next = column_boundary_flags_next
                                 | (gblf_pkg::ColFlagW'(1) << current_col);
    end
    if (last_col && nz) begin
      column_boundary_flags_next = column_boundary_flags_next
                                 | (gblf_pkg::ColFlagW'(1) << cols);
    end
    if (nz != above) begin
      row_boundary_flags_next = row_boundary_flags_next
                              | (gblf_pkg::RowFlagW'(1) << current_row);
    end
    if (last_row && nz) begin
      row_boundary_flags_next = row_boundary_flags_next
                              | (gblf_pkg::RowFlagW'(1) << rows);
    end
    previous_row_mask_next[current_col] = nz;
    if (last_col) begin
      current_col_next       = '0;
      left_cell_nonzero_next = 1'b0;
      current_row_next       = current_row + gblf_pkg::RowIdxW'(1);
    end
  end

  assign push               = accept && last_col && last_row;
  assign push_job.col_flags = column_boundary_flags_next;
  assign push_job.row_flags = row_boundary_flags_next;

  always_ff @(posedge clk) begin
    if (rst || clear || push) begin
      previous_row_mask     <= '0;
      column_boundary_flags <= '0;
      row_boundary_flags    <= '0;
      left_cell_nonzero     <= 1'b0;
      current_row           <= '0;
      current_col           <= '0;
    end else if (accept) begin
      previous_row_mask     <= previous_row_mask_next;
      column_boundary_flags <= column_boundary_flags_next;
      row_boundary_flags    <= row_boundary_flags_next;
      left_cell_nonzero     <= left_cell_nonzero_next;
      current_row           <= current_row_next;
      current_col           <= current_col_next;
    end
  end

endmodule

// File: src/gblf_queue.sv
// ----------------------------------------------------------------------------
// gblf_queue
// Two-entry queue of finished grids between the front and the back.
// ----------------------------------------------------------------------------
module gblf_queue (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  input  gblf_pkg::job_t          push_job,
  input  logic                    pop,
  output gblf_pkg::job_t          pop_job,
  output gblf_pkg::queue_status_t status
);

  gblf_pkg::job_t mem [2];
  logic           wr_ptr, rd_ptr;
  logic [1:0]     count;

  assign status.full  = (count == 2'd2);
  assign status.empty = (count == 2'd0);
  assign pop_job      = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// File: src/gblf_back.sv
// ----------------------------------------------------------------------------
// gblf_back
// Drains finished grids as header and position beats, column list first.
// ----------------------------------------------------------------------------
module gblf_back (
  input  logic                          clk,
  input  logic                          rst,
  input  gblf_pkg::queue_status_t       q_status,
  input  gblf_pkg::job_t                pop_job,
  output logic                          pop,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          entry_kind,
  output logic                          axis,
  output logic [gblf_pkg::EntryW-1:0]   entry_value,
  output logic                          last_entry
);

  gblf_pkg::back_state_t         state, state_next;
  logic [gblf_pkg::ColFlagW-1:0] col_flags, col_flags_next;
  logic [gblf_pkg::RowFlagW-1:0] row_flags, row_flags_next;
  logic                          out_valid_next;
  logic                          kind_next, axis_next, last_next;
  logic [gblf_pkg::EntryW-1:0]   value_next;
  logic                          adv;
  logic [gblf_pkg::ColFlagW-1:0] col_rest;
  logic [gblf_pkg::RowFlagW-1:0] row_rest;

  assign adv      = !out_valid || !out_stall;
  assign col_rest = col_flags & (col_flags - gblf_pkg::ColFlagW'(1));
  assign row_rest = row_flags & (row_flags - gblf_pkg::RowFlagW'(1));

  always_comb begin
    state_next     = state;
    col_flags_next = col_flags;
    row_flags_next = row_flags;
    pop            = 1'b0;
    out_valid_next = out_valid && out_stall;
    kind_next      = entry_kind;
    axis_next      = axis;
    value_next     = entry_value;
    last_next      = last_entry;
    case (state)
      gblf_pkg::BK_IDLE: begin
        if (!q_status.empty) begin
          pop            = 1'b1;
          col_flags_next = pop_job.col_flags;
          row_flags_next = pop_job.row_flags;
          state_next     = gblf_pkg::BK_COL_HDR;
        end
      end
      gblf_pkg::BK_COL_HDR: begin
        if (adv) begin
          out_valid_next = 1'b1;
          kind_next      = gblf_pkg::KindHeader;
          axis_next      = gblf_pkg::AxisCol;
          value_next     = gblf_pkg::EntryW'($countones(col_flags));
          last_next      = 1'b0;
          state_next     = (col_flags != '0) ? gblf_pkg::BK_COL_POS : gblf_pkg::BK_ROW_HDR;
        end
      end
      gblf_pkg::BK_COL_POS: begin
        if (adv) begin
          out_valid_next = 1'b1;
          kind_next      = gblf_pkg::KindPosition;
          axis_next      = gblf_pkg::AxisCol;
          value_next     = gblf_pkg::lowest_set({{gblf_pkg::RowFlagW{1'b0}}, col_flags});
          last_next      = 1'b0;
          col_flags_next = col_rest;
          if (col_rest == '0) begin
            state_next = gblf_pkg::BK_ROW_HDR;
          end
        end
      end
      gblf_pkg::BK_ROW_HDR: begin
        if (adv) begin
          out_valid_next = 1'b1;
          kind_next      = gblf_pkg::KindHeader;
          axis_next      = gblf_pkg::AxisRow;
          value_next     = gblf_pkg::EntryW'($countones(row_flags));
          last_next      = (row_flags == '0);
          state_next     = (row_flags != '0) ? gblf_pkg::BK_ROW_POS : gblf_pkg::BK_IDLE;
        end
      end
      gblf_pkg::BK_ROW_POS: begin
        if (adv) begin
          out_valid_next = 1'b1;
          kind_next      = gblf_pkg::KindPosition;
          axis_next      = gblf_pkg::AxisRow;
          value_next     = gblf_pkg::lowest_set({{gblf_pkg::ColFlagW{1'b0}}, row_flags});
          last_next      = (row_rest == '0);
          row_flags_next = row_rest;
          if (row_rest == '0) begin
            state_next = gblf_pkg::BK_IDLE;
          end
        end
      end
      default: begin
        state_next = gblf_pkg::BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= gblf_pkg::BK_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    col_flags   <= col_flags_next;
    row_flags   <= row_flags_next;
    entry_kind  <= kind_next;
    axis        <= axis_next;
    entry_value <= value_next;
    last_entry  <= last_next;
  end

endmodule

// File: src/grid_boundary_line_finder.sv
// ----------------------------------------------------------------------------
// grid_boundary_line_finder
// Finds column and row boundaries of a raster grid and lists them.
// ----------------------------------------------------------------------------
// Cells enter one per cycle in raster order; the front marks boundaries as
// they arrive and stalls only when two finished grids already wait in the
// queue. After the last cell of a grid the back drains one beat per cycle
// while out_stall is low: column header, column positions, row header, row
// positions, so a grid of n marked boundaries takes n + 2 beats once the back
// has fetched it from the queue. The next grid streams in while the previous
// one drains. Writing grid_rows or grid_cols discards any partly received grid.
// ----------------------------------------------------------------------------
module grid_boundary_line_finder (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [gblf_pkg::AddrW-1:0]        paddr,
  input  logic [gblf_pkg::DataW-1:0]        pwdata,
  output logic [gblf_pkg::DataW-1:0]        prdata,
  output logic                              pready,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [31:0]                cell_value,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              entry_kind,
  output logic                              axis,
  output logic [gblf_pkg::EntryW-1:0]       entry_value,
  output logic                              last_entry
);

  logic [gblf_pkg::RegW-1:0]     grid_rows, grid_cols;
  logic [gblf_pkg::RowSizeW-1:0] rows_eff;
  logic [gblf_pkg::ColSizeW-1:0] cols_eff;
  logic                          cfg_write;
  logic                          push, pop;
  gblf_pkg::job_t                push_job, pop_job;
  gblf_pkg::queue_status_t       q_status;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_rows <= gblf_pkg::RegW'(16);
      grid_cols <= gblf_pkg::RegW'(16);
    end else if (cfg_write) begin
      if (paddr[2] == gblf_pkg::AddrGridCols[2]) begin
        grid_cols <= pwdata[gblf_pkg::RegW-1:0];
      end else begin
        grid_rows <= pwdata[gblf_pkg::RegW-1:0];
      end
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == gblf_pkg::AddrGridRows[2]) begin
      prdata[gblf_pkg::RegW-1:0] = grid_rows;
    end else begin
      prdata[gblf_pkg::RegW-1:0] = grid_cols;
    end
  end

  always_comb begin
    if (grid_rows == '0) begin
      rows_eff = gblf_pkg::RowSizeW'(1);
    end else if (32'(grid_rows) > gblf_pkg::MaxRows) begin
      rows_eff = gblf_pkg::RowSizeW'(gblf_pkg::MaxRows);
    end else begin
      rows_eff = gblf_pkg::RowSizeW'(grid_rows);
    end
    if (grid_cols == '0) begin
      cols_eff = gblf_pkg::ColSizeW'(1);
    end else if (32'(grid_cols) > gblf_pkg::MaxCols) begin
      cols_eff = gblf_pkg::ColSizeW'(gblf_pkg::MaxCols);
    end else begin
      cols_eff = gblf_pkg::ColSizeW'(grid_cols);
    end
  end

  gblf_front u_front (
    .clk        (clk),
    .rst        (rst),
    .clear      (cfg_write),
    .rows       (rows_eff),
    .cols       (cols_eff),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .cell_value (cell_value),
    .q_status   (q_status),
    .push       (push),
    .push_job   (push_job)
  );

  gblf_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .pop_job  (pop_job),
    .status   (q_status)
  );

  gblf_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_status    (q_status),
    .pop_job     (pop_job),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .entry_kind  (entry_kind),
    .axis        (axis),
    .entry_value (entry_value),
    .last_entry  (last_entry)
  );

endmodule

// File: verif/boundary_list_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// boundary_list_checker
// Watches the configuration port and both streams of the grid boundary line
// finder. Every accepted cell is folded into a private copy of the grid state.
// When a grid completes, its column and row lists are queued, and each output
// beat is compared field by field against the oldest queued entry.
// ----------------------------------------------------------------------------
module boundary_list_checker (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic                        pready,
  input  logic [gblf_pkg::AddrW-1:0]  paddr,
  input  logic [gblf_pkg::DataW-1:0]  pwdata,
  input  logic                        in_valid,
  input  logic                        in_stall,
  input  logic signed [31:0]          cell_value,
  input  logic                        out_valid,
  input  logic                        out_stall,
  input  logic                        entry_kind,
  input  logic                        axis,
  input  logic [gblf_pkg::EntryW-1:0] entry_value,
  input  logic                        last_entry,
  output int                          entries_due,
  output int                          mismatches
);

  typedef struct packed {
    logic                        kind;
    logic                        ax;
    logic [gblf_pkg::EntryW-1:0] val;
    logic                        last;
  } list_entry_t;

  logic [gblf_pkg::RegW-1:0]     rows_reg;
  logic [gblf_pkg::RegW-1:0]     cols_reg;
  logic [gblf_pkg::MaxCols-1:0]  upper_row_nz;
  logic [gblf_pkg::ColFlagW-1:0] col_marks;
  logic [gblf_pkg::RowFlagW-1:0] row_marks;
  logic                          left_nz;
  int                            row_at;
  int                            col_at;
  int                            err_tally;
  list_entry_t                   lists_due[$];

  function automatic int clamp_span(input logic [gblf_pkg::RegW-1:0] v, input int hi);
    if (v == 0) return 1;
    if (int'(v) > hi) return hi;
    return int'(v);
  endfunction

  task automatic clear_grid();
    upper_row_nz = '0;
    col_marks = '0;
    row_marks = '0;
    left_nz = 1'b0;
    row_at = 0;
    col_at = 0;
  endtask

  task automatic list_boundaries(input logic ax, input logic [31:0] marks, input int span,
                                 input bit closes);
    int remaining;
    list_entry_t e;
    remaining = 0;
    for (int p = 0; p <= span; p++) begin
      if (marks[p]) remaining++;
    end
    e.kind = gblf_pkg::KindHeader;
    e.ax = ax;
    e.val = gblf_pkg::EntryW'(remaining);
    e.last = closes && remaining == 0;
    lists_due.insert(lists_due.size(), e);
    for (int p = 0; p <= span; p++) begin
      if (marks[p]) begin
        remaining--;
        e.kind = gblf_pkg::KindPosition;
        e.val = gblf_pkg::EntryW'(p);
        e.last = closes && remaining == 0;
        lists_due.insert(lists_due.size(), e);
      end
    end
  endtask

  task automatic fold_cell(input logic [31:0] v);
    int   nrows;
    int   ncols;
    int   c;
    int   r;
    logic nz;
    logic above;
    nrows = clamp_span(rows_reg, gblf_pkg::MaxRows);
    ncols = clamp_span(cols_reg, gblf_pkg::MaxCols);
    c = (col_at >= ncols) ? ncols - 1 : col_at;
    r = (row_at >= nrows) ? nrows - 1 : row_at;
    nz = (v != 0);
    if (nz != left_nz) col_marks[c] = 1'b1;
    if (c + 1 == ncols && nz) col_marks[ncols] = 1'b1;
    above = (r == 0) ? 1'b0 : upper_row_nz[c];
    if (nz != above) row_marks[r] = 1'b1;
    if (r + 1 == nrows && nz) row_marks[nrows] = 1'b1;
    upper_row_nz[c] = nz;
    left_nz = nz;
    c++;
    if (c >= ncols) begin
      c = 0;
      left_nz = 1'b0;
      r++;
    end
    col_at = c;
    row_at = r;
    if (r >= nrows) begin
      list_boundaries(gblf_pkg::AxisCol, 32'(col_marks), ncols, 1'b0);
      list_boundaries(gblf_pkg::AxisRow, 32'(row_marks), nrows, 1'b1);
      clear_grid();
    end
  endtask

  always @(posedge clk) begin : watch
    list_entry_t seen;
    list_entry_t want;
    if (rst) begin
      rows_reg = gblf_pkg::RegW'(gblf_pkg::MaxRows);
      cols_reg = gblf_pkg::RegW'(gblf_pkg::MaxCols);
      clear_grid();
      lists_due.delete();
      err_tally = 0;
    end else begin
      if (out_valid && !out_stall) begin
        seen = {entry_kind, axis, entry_value, last_entry};
        if (lists_due.size() == 0) begin
          err_tally++;
          if (err_tally <= 10)
            $display("unexpected beat: kind %0d axis %0d value %0d last %0d",
                     seen.kind, seen.ax, seen.val, seen.last);
        end else begin
          want = lists_due.pop_front();
          if (seen !== want) begin
            err_tally++;
            if (err_tally <= 10)
              $display("mismatch: expected kind %0d axis %0d value %0d last %0d,",
                       want.kind, want.ax, want.val, want.last,
                       " got kind %0d axis %0d value %0d last %0d",
                       seen.kind, seen.ax, seen.val, seen.last);
          end
        end
      end
      if (psel && penable && pwrite && pready) begin
        if (paddr == gblf_pkg::AddrGridRows) begin
          rows_reg = pwdata[gblf_pkg::RegW-1:0];
          clear_grid();
        end else if (paddr == gblf_pkg::AddrGridCols) begin
          cols_reg = pwdata[gblf_pkg::RegW-1:0];
          clear_grid();
        end
      end
      if (in_valid && !in_stall) fold_cell(cell_value);
    end
    entries_due <= lists_due.size();
    mismatches <= err_tally;
  end

endmodule

// File: verif/grid_boundary_line_finder_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// grid_boundary_line_finder_test
// Drives grids of cells through the boundary line finder under a range of
// grid sizes, including zero and oversized size registers and discarded
// partial grids, with random gaps on the input and random stalls on the
// output. A checker beside the block predicts and compares every list beat.
// ----------------------------------------------------------------------------
module grid_boundary_line_finder_test;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          psel = 1'b0;
  logic                          penable = 1'b0;
  logic                          pwrite = 1'b0;
  logic [gblf_pkg::AddrW-1:0]    paddr = '0;
  logic [gblf_pkg::DataW-1:0]    pwdata = '0;
  logic [gblf_pkg::DataW-1:0]    prdata;
  logic                          pready;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  logic signed [31:0]            cell_value = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic                          entry_kind;
  logic                          axis;
  logic [gblf_pkg::EntryW-1:0]   entry_value;
  logic                          last_entry;
  int                            entries_due;
  int                            mismatches;

  logic [gblf_pkg::RegW-1:0]     rows_raw = gblf_pkg::RegW'(gblf_pkg::MaxRows);
  logic [gblf_pkg::RegW-1:0]     cols_raw = gblf_pkg::RegW'(gblf_pkg::MaxCols);
  int                            cells_sent = 0;
  int                            drain_hold = 0;
  bit                            feed_calm = 1'b0;
  bit                            drain_calm = 1'b0;

  grid_boundary_line_finder uut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_stall(in_stall), .cell_value(cell_value),
    .out_valid(out_valid), .out_stall(out_stall), .entry_kind(entry_kind),
    .axis(axis), .entry_value(entry_value), .last_entry(last_entry)
  );

  boundary_list_checker lists_check (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata),
    .in_valid(in_valid), .in_stall(in_stall), .cell_value(cell_value),
    .out_valid(out_valid), .out_stall(out_stall), .entry_kind(entry_kind),
    .axis(axis), .entry_value(entry_value), .last_entry(last_entry),
    .entries_due(entries_due), .mismatches(mismatches)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    #10_000_000;
    $display("TB_ERROR");
    $finish;
  end

  function automatic int next_gap(input bit calm);
    if (calm) return 0;
    case ($urandom_range(0, 3))
      0: return 0;
      1: return $urandom_range(1, 3);
      default: return $urandom_range(0, 14);
    endcase
  endfunction

  function automatic int span_of(input logic [gblf_pkg::RegW-1:0] v, input int hi);
    if (v == 0) return 1;
    if (int'(v) > hi) return hi;
    return int'(v);
  endfunction

  function automatic logic [gblf_pkg::RegW-1:0] pick_size();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return gblf_pkg::RegW'(16);
      2: return gblf_pkg::RegW'($urandom_range(17, 31));
      default: return gblf_pkg::RegW'($urandom_range(1, 4));
    endcase
  endfunction

  function automatic logic [31:0] draw_cell(input int density);
    if ($urandom_range(0, 99) >= density) return '0;
    case ($urandom_range(0, 5))
      0: return 32'd1 << $urandom_range(0, 31);
      1: return '1;
      2: return 32'h8000_0000;
      default: return $urandom();
    endcase
  endfunction

  function automatic int pick_density();
    case ($urandom_range(0, 4))
      0: return 0;
      1: return 15;
      2: return 50;
      3: return 85;
      default: return 100;
    endcase
  endfunction

  // random stall after each accepted output beat
  always @(posedge clk) begin : drain_ctl
    int gap;
    if (rst) begin
      drain_hold <= 0;
      out_stall <= 1'b0;
    end else if (drain_hold != 0) begin
      drain_hold <= drain_hold - 1;
      out_stall <= (drain_hold > 1);
    end else if (out_valid && !out_stall) begin
      if ($urandom_range(0, 24) == 0) drain_calm = !drain_calm;
      gap = next_gap(drain_calm);
      drain_hold <= gap;
      out_stall <= (gap != 0);
    end
  end

  task automatic write_size(input logic [gblf_pkg::AddrW-1:0] addr,
                            input logic [gblf_pkg::RegW-1:0] raw);
    logic [gblf_pkg::DataW-1:0] word;
    word = ($urandom_range(0, 3) == 0) ? $urandom() : '0;
    word[gblf_pkg::RegW-1:0] = raw;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= word;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    if (addr == gblf_pkg::AddrGridRows) rows_raw = raw;
    else cols_raw = raw;
  endtask

  task automatic push_cell(input logic [31:0] v);
    int gap;
    if ($urandom_range(0, 24) == 0) feed_calm = !feed_calm;
    gap = next_gap(feed_calm);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    cell_value <= v;
    do @(posedge clk); while (in_stall);
    cells_sent++;
  endtask

  // drain all pending lists before touching the size registers
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (entries_due != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  initial begin
    int                          which;
    int                          cell_total;
    int                          density;
    logic [gblf_pkg::RegW-1:0]   r_raw;
    logic [gblf_pkg::RegW-1:0]   c_raw;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // single-cell grids with value extremes
    write_size(gblf_pkg::AddrGridRows, gblf_pkg::RegW'(1));
    write_size(gblf_pkg::AddrGridCols, gblf_pkg::RegW'(1));
    push_cell(32'd0);
    push_cell(32'd1);
    push_cell(32'h8000_0000);
    push_cell(32'h7fff_ffff);
    push_cell(32'hffff_ffff);
    wait_idle();

    // zero rows treated as one
    write_size(gblf_pkg::AddrGridRows, gblf_pkg::RegW'(0));
    write_size(gblf_pkg::AddrGridCols, gblf_pkg::RegW'(3));
    push_cell(32'd5);
    push_cell(32'd0);
    push_cell(32'd7);
    wait_idle();

    // zero cols treated as one
    write_size(gblf_pkg::AddrGridRows, gblf_pkg::RegW'(2));
    write_size(gblf_pkg::AddrGridCols, gblf_pkg::RegW'(0));
    push_cell(32'd0);
    push_cell(32'h0000_0100);
    wait_idle();

    // partial grid dropped by a register write
    write_size(gblf_pkg::AddrGridCols, gblf_pkg::RegW'(2));
    push_cell(32'd1);
    push_cell(32'd0);
    wait_idle();
    write_size(gblf_pkg::AddrGridCols, gblf_pkg::RegW'(2));
    push_cell(32'd0);
    push_cell(32'h4000_0000);
    push_cell(32'd3);
    push_cell(32'd0);
    wait_idle();

    while (cells_sent < 230) begin
      which = $urandom_range(0, 2);
      r_raw = (which != 1) ? pick_size() : rows_raw;
      c_raw = (which != 0) ? pick_size() : cols_raw;
      if (span_of(r_raw, gblf_pkg::MaxRows) * span_of(c_raw, gblf_pkg::MaxCols) > 64) begin
        if (which == 1 || (which == 2 && $urandom_range(0, 1) == 1))
          c_raw = gblf_pkg::RegW'($urandom_range(1, 3));
        else
          r_raw = gblf_pkg::RegW'($urandom_range(1, 3));
      end
      if (which != 1) write_size(gblf_pkg::AddrGridRows, r_raw);
      if (which != 0) write_size(gblf_pkg::AddrGridCols, c_raw);
      cell_total = span_of(rows_raw, gblf_pkg::MaxRows) * span_of(cols_raw, gblf_pkg::MaxCols);
      repeat ($urandom_range(1, 3)) begin
        density = pick_density();
        repeat (cell_total) push_cell(draw_cell(density));
      end
      if (cell_total > 1 && $urandom_range(0, 3) == 0)
        repeat ($urandom_range(1, cell_total - 1)) push_cell(draw_cell(50));
      wait_idle();
    end

    repeat (16) @(posedge clk);
    if (mismatches == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule

// File: grid_boundary_line_finder.f
src/gblf_pkg.sv
src/gblf_front.sv
src/gblf_queue.sv
src/gblf_back.sv
src/grid_boundary_line_finder.sv
verif/boundary_list_checker.sv
verif/grid_boundary_line_finder_test.sv
